### rtl/core/assert_macros.svh
// assertion helpers, sampled on the rising clock edge and off while in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define DCIL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked in the same cycle
`define DCIL_ASSERT_IMPL(label, pre, post, msg) \
  `DCIL_ASSERT(label, (pre) |-> (post), msg)

// implication checked in the cycle after the antecedent
`define DCIL_ASSERT_NEXT(label, pre, post, msg) \
  `DCIL_ASSERT(label, (pre) |=> (post), msg)

`endif

### rtl/core/dcil_pkg.sv
`default_nettype none

package dcil_pkg;

  typedef enum logic [2:0] {
    EV_ACK   = 3'd0,
    EV_BELT  = 3'd1,
    EV_BLOCK = 3'd2,
    EV_OBST  = 3'd3,
    EV_LIMIT = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    DIR_STOP  = 3'd0,
    DIR_FWD   = 3'd1,
    DIR_BACK  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_e;

  typedef enum logic [2:0] {
    REG_DUTY_START     = 3'd0,
    REG_DUTY_MIN       = 3'd1,
    REG_DUTY_WARN      = 3'd2,
    REG_DUTY_MAX       = 3'd3,
    REG_DUTY_STEP      = 3'd4,
    REG_BLOCK_DISTANCE = 3'd5,
    REG_NO_OBJECT_CODE = 3'd6
  } reg_e;

  localparam logic [7:0] CMD_UP    = 8'h55;  // U
  localparam logic [7:0] CMD_DOWN  = 8'h44;  // D
  localparam logic [7:0] CMD_STOP  = 8'h53;  // S
  localparam logic [7:0] CMD_FWD   = 8'h46;  // F
  localparam logic [7:0] CMD_BACK  = 8'h42;  // B
  localparam logic [7:0] CMD_LEFT  = 8'h4C;  // L
  localparam logic [7:0] CMD_RIGHT = 8'h52;  // R

  localparam logic [7:0]  DUTY_START_RST     = 8'd128;
  localparam logic [7:0]  DUTY_MIN_RST       = 8'd32;
  localparam logic [7:0]  DUTY_WARN_RST      = 8'd200;
  localparam logic [7:0]  DUTY_MAX_RST       = 8'd230;
  localparam logic [7:0]  DUTY_STEP_RST      = 8'd16;
  localparam logic [15:0] BLOCK_DISTANCE_RST = 16'd20;
  localparam logic [15:0] NO_OBJECT_CODE_RST = 16'hFFFF;

  typedef struct packed {
    logic        mode;
    logic [7:0]  cmd_byte;
    logic        belt_on;
    logic [15:0] front_distance;
    logic [15:0] left_distance;
    logic [15:0] right_distance;
  } dcil_in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  letter;
    logic [2:0]  motor_dir;
    logic [7:0]  duty;
    logic [7:0]  req_duty;
    logic [15:0] distance_cm;
    logic        near_limit;
    logic        last;
  } dcil_out_t;

  // one accepted item worth of results, one or two of them
  typedef struct packed {
    dcil_out_t first;
    dcil_out_t second;
    logic      two;
  } dcil_pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dcil_qstat_t;

  function automatic logic [7:0] dir_letter(input dir_e dir);
    logic [7:0] l;
    unique case (dir)
      DIR_FWD:   l = CMD_FWD;
      DIR_BACK:  l = CMD_BACK;
      DIR_LEFT:  l = CMD_LEFT;
      DIR_RIGHT: l = CMD_RIGHT;
      default:   l = CMD_STOP;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

### rtl/core/dcil_front.sv
`default_nettype none

module dcil_front
  import dcil_pkg::*;
#(
  parameter int DISTANCE_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic       accept_i,
  input  wire dcil_in_t   item_i,
  output logic            pkt_valid_o,
  output dcil_pkt_t       pkt_o
);

  logic [7:0]  duty_start_q, duty_min_q, duty_warn_q, duty_max_q, duty_step_q;
  logic [15:0] block_distance_q, no_object_code_q;

  dir_e                     motion_q, motion_d;
  logic [7:0]               duty_q, duty_d;
  logic [DISTANCE_BITS-1:0] front_q, left_q, right_q;
  logic [DISTANCE_BITS-1:0] front_d, left_d, right_d;

  dcil_out_t  r1, r2;
  logic       r1_v, r2_v;
  dir_e       m_after, cmd_dir, dir_sel;
  logic [7:0] req, thr;
  logic [15:0] sel_dist;
  logic       has_dist, blk;
  logic       is_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_start_q     <= DUTY_START_RST;
      duty_min_q       <= DUTY_MIN_RST;
      duty_warn_q      <= DUTY_WARN_RST;
      duty_max_q       <= DUTY_MAX_RST;
      duty_step_q      <= DUTY_STEP_RST;
      block_distance_q <= BLOCK_DISTANCE_RST;
      no_object_code_q <= NO_OBJECT_CODE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DUTY_START:     duty_start_q     <= cfg_data_i[7:0];
        REG_DUTY_MIN:       duty_min_q       <= cfg_data_i[7:0];
        REG_DUTY_WARN:      duty_warn_q      <= cfg_data_i[7:0];
        REG_DUTY_MAX:       duty_max_q       <= cfg_data_i[7:0];
        REG_DUTY_STEP:      duty_step_q      <= cfg_data_i[7:0];
        REG_BLOCK_DISTANCE: block_distance_q <= cfg_data_i;
        REG_NO_OBJECT_CODE: no_object_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_q <= DIR_STOP;
      duty_q   <= DUTY_START_RST;
      front_q  <= '1;
      left_q   <= '1;
      right_q  <= '1;
    end else if (accept_i) begin
      motion_q <= motion_d;
      duty_q   <= duty_d;
      front_q  <= front_d;
      left_q   <= left_d;
      right_q  <= right_d;
    end
  end

  // command decode
  always_comb begin
    is_move = 1'b1;
    cmd_dir = DIR_STOP;
    unique case (item_i.cmd_byte)
      CMD_FWD:   cmd_dir = DIR_FWD;
      CMD_BACK:  cmd_dir = DIR_BACK;
      CMD_LEFT:  cmd_dir = DIR_LEFT;
      CMD_RIGHT: cmd_dir = DIR_RIGHT;
      default:   is_move = 1'b0;
    endcase
  end

  // distance stores after this item and the block check
  always_comb begin
    if (item_i.mode) begin
      front_d = item_i.front_distance[DISTANCE_BITS-1:0];
      left_d  = item_i.left_distance[DISTANCE_BITS-1:0];
      right_d = item_i.right_distance[DISTANCE_BITS-1:0];
      dir_sel = motion_q;
    end else begin
      front_d = front_q;
      left_d  = left_q;
      right_d = right_q;
      dir_sel = cmd_dir;
    end
    has_dist = 1'b1;
    unique case (dir_sel)
      DIR_FWD:   sel_dist = 16'(front_d);
      DIR_LEFT:  sel_dist = 16'(left_d);
      DIR_RIGHT: sel_dist = 16'(right_d);
      default: begin
        sel_dist = '0;
        has_dist = 1'b0;
      end
    endcase
    blk = has_dist && (sel_dist != no_object_code_q) && (sel_dist <= block_distance_q);
  end

  always_comb begin
    r1       = '0;
    r2       = '0;
    r1_v     = 1'b0;
    r2_v     = 1'b0;
    motion_d = motion_q;
    duty_d   = duty_q;
    m_after  = motion_q;
    req      = duty_q + duty_step_q;
    thr      = duty_min_q + duty_step_q;

    if (item_i.mode) begin
      if (blk) begin
        motion_d          = DIR_STOP;
        r2_v              = 1'b1;
        r2.event_res      = EV_OBST;
        r2.letter         = dir_letter(motion_q);
        r2.motor_dir      = DIR_STOP;
        r2.duty           = duty_q;
        r2.distance_cm    = sel_dist;
      end
    end else begin
      // belt dropped while moving stops the motor first
      if (!item_i.belt_on && motion_q != DIR_STOP) begin
        r1_v         = 1'b1;
        r1.event_res = EV_BELT;
        r1.letter    = dir_letter(motion_q);
        r1.motor_dir = DIR_STOP;
        r1.duty      = duty_q;
        m_after      = DIR_STOP;
      end
      motion_d = m_after;
      r2.letter    = item_i.cmd_byte;
      r2.motor_dir = m_after;
      r2.duty      = duty_q;
      if (item_i.cmd_byte == CMD_UP) begin
        r2_v        = 1'b1;
        r2.req_duty = req;
        if (req > duty_max_q) begin
          duty_d       = duty_start_q;
          motion_d     = DIR_STOP;
          r2.event_res = EV_LIMIT;
          r2.motor_dir = DIR_STOP;
          r2.duty      = duty_start_q;
        end else begin
          duty_d        = req;
          r2.event_res  = EV_ACK;
          r2.duty       = req;
          r2.near_limit = (req >= duty_warn_q);
        end
      end else if (item_i.cmd_byte == CMD_DOWN) begin
        r2_v         = 1'b1;
        r2.event_res = EV_ACK;
        duty_d       = (duty_q <= thr) ? duty_min_q : duty_q - duty_step_q;
        r2.duty      = duty_d;
      end else if (item_i.cmd_byte == CMD_STOP) begin
        r2_v         = 1'b1;
        r2.event_res = EV_ACK;
        motion_d     = DIR_STOP;
        r2.motor_dir = DIR_STOP;
      end else if (is_move) begin
        r2_v = 1'b1;
        if (!item_i.belt_on) begin
          motion_d     = DIR_STOP;
          r2.event_res = EV_BELT;
          r2.motor_dir = DIR_STOP;
        end else if (blk) begin
          motion_d       = DIR_STOP;
          r2.event_res   = EV_BLOCK;
          r2.motor_dir   = DIR_STOP;
          r2.distance_cm = sel_dist;
        end else begin
          motion_d     = cmd_dir;
          r2.event_res = EV_ACK;
          r2.motor_dir = cmd_dir;
        end
      end
    end
  end

  // pack results in order, last marks the final one
  always_comb begin
    pkt_o = '0;
    if (r1_v && r2_v) begin
      pkt_o.first       = r1;
      pkt_o.second      = r2;
      pkt_o.second.last = 1'b1;
      pkt_o.two         = 1'b1;
    end else if (r1_v) begin
      pkt_o.first      = r1;
      pkt_o.first.last = 1'b1;
    end else begin
      pkt_o.first      = r2;
      pkt_o.first.last = 1'b1;
    end
    pkt_valid_o = accept_i && (r1_v || r2_v);
  end

endmodule

`default_nettype wire

### rtl/core/dcil_queue.sv
`default_nettype none

module dcil_queue
  import dcil_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_i,
  input  wire dcil_pkt_t wr_pkt_i,
  input  wire logic  rd_i,
  output dcil_pkt_t  rd_pkt_o,
  output dcil_qstat_t stat_o
);

  localparam int AW = $clog2(DEPTH);

  dcil_pkt_t   mem_q [DEPTH];
  logic [AW:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0] fill;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q[AW-1:0]] <= wr_pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_i) rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  assign fill         = wr_ptr_q - rd_ptr_q;
  assign stat_o.full  = (fill == (AW+1)'(DEPTH));
  assign stat_o.empty = (fill == '0);
  assign rd_pkt_o     = mem_q[rd_ptr_q[AW-1:0]];

endmodule

`default_nettype wire

### rtl/core/dcil_back.sv
`default_nettype none

module dcil_back
  import dcil_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_empty_i,
  input  wire dcil_pkt_t q_pkt_i,
  output logic      q_pop_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output dcil_out_t item_o
);

  logic      out_valid_q, out_valid_d;
  logic      sec_valid_q, sec_valid_d;
  dcil_out_t out_q, out_d;
  dcil_out_t sec_q, sec_d;
  logic      advance;

  assign advance = !out_valid_q || pop_i;
  assign q_pop_o = advance && !sec_valid_q && !q_empty_i;

  always_comb begin
    out_valid_d = out_valid_q;
    sec_valid_d = sec_valid_q;
    out_d       = out_q;
    sec_d       = sec_q;
    if (advance) begin
      if (sec_valid_q) begin
        out_d       = sec_q;
        out_valid_d = 1'b1;
        sec_valid_d = 1'b0;
      end else if (!q_empty_i) begin
        out_d       = q_pkt_i.first;
        out_valid_d = 1'b1;
        sec_d       = q_pkt_i.second;
        sec_valid_d = q_pkt_i.two;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sec_valid_q <= sec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sec_q <= sec_d;
  end

  assign empty_o = !out_valid_q;
  assign item_o  = out_q;

endmodule

`default_nettype wire

### rtl/core/drive_command_interlock_core.sv
// results: an accepted item's results go into the result queue, then into the output register
// throughput: one item per cycle while the result queue has room; results
// leave one per cycle at the output register while popped, and a two-result item holds it for both
// reset: motion stopped, duty and registers at their reset values, queue empty
`default_nettype none

module drive_command_interlock_core
  import dcil_pkg::*;
#(
  parameter int DISTANCE_BITS = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire dcil_in_t    in_item_i,
  output logic             empty,
  input  wire logic        pop,
  output dcil_out_t        out_item_o
);

  logic        accept;
  logic        pkt_valid;
  dcil_pkt_t   pkt_wr, pkt_rd;
  logic        q_pop;
  dcil_qstat_t qstat;

  assign cfg_ready_o = 1'b1;
  assign full        = qstat.full;
  assign accept      = push && !qstat.full;

  dcil_front #(
    .DISTANCE_BITS(DISTANCE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .pkt_valid_o(pkt_valid),
    .pkt_o      (pkt_wr)
  );

  dcil_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (pkt_valid),
    .wr_pkt_i(pkt_wr),
    .rd_i    (q_pop),
    .rd_pkt_o(pkt_rd),
    .stat_o  (qstat)
  );

  dcil_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(qstat.empty),
    .q_pkt_i  (pkt_rd),
    .q_pop_o  (q_pop),
    .pop_i    (pop),
    .empty_o  (empty),
    .item_o   (out_item_o)
  );

endmodule

`default_nettype wire

### rtl/core/dcil_checker.sv
`default_nettype none
`include "assert_macros.svh"

module dcil_checker
  import dcil_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [2:0]  cfg_index_i,
  input wire logic [15:0] cfg_data_i,
  input wire logic        push,
  input wire logic        full,
  input wire dcil_in_t    in_item_i,
  input wire logic        empty,
  input wire logic        pop,
  input wire dcil_out_t   out_item_o
);

  logic stop_event;
  logic unused_ok;

  assign stop_event = (out_item_o.event_res == EV_BELT) || (out_item_o.event_res == EV_BLOCK) ||
                      (out_item_o.event_res == EV_OBST) || (out_item_o.event_res == EV_LIMIT);
  assign unused_ok  = cfg_valid_i ^ cfg_ready_o ^ (^cfg_index_i) ^ (^cfg_data_i) ^ push ^
                      full ^ (^in_item_i);

  `DCIL_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_item_o), "result changed while waiting")
  `DCIL_ASSERT_IMPL(a_event_range, !empty, out_item_o.event_res <= EV_LIMIT, "event code out of range")
  `DCIL_ASSERT_IMPL(a_stop_dir, !empty && stop_event, out_item_o.motor_dir == DIR_STOP, "stop event with motor moving")
  `DCIL_ASSERT_IMPL(a_near_on_up, !empty && out_item_o.near_limit, (out_item_o.event_res == EV_ACK) && (out_item_o.letter == CMD_UP), "near limit outside increase ack")

endmodule

bind drive_command_interlock_core dcil_checker u_chk (.*);

`default_nettype wire

### bench/dcil_result_checker.sv
module dcil_result_checker
  import dcil_pkg::*;
#(
  parameter int DIST_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        push_i,
  input  wire logic        full_i,
  input  dcil_in_t         in_item_i,
  input  wire logic        empty_i,
  input  wire logic        pop_i,
  input  dcil_out_t        out_item_i,
  output int               pending_o,
  output int               failures_o,
  output int               checked_o
);

  localparam logic [15:0] DIST_MASK = 16'((32'd1 << DIST_BITS) - 1);

  // settings as last written
  logic [7:0]  set_start, set_min, set_warn, set_max, set_step;
  logic [15:0] set_block_cm, set_no_echo;

  // drive state as the block should hold it
  dir_e        motion;
  logic [7:0]  duty_now;
  logic [15:0] front_cm, left_cm, right_cm;

  dcil_out_t   awaited_reports[$];
  int          fail_total;
  int          checked_total;

  function automatic logic [7:0] motion_letter(input dir_e d);
    case (d)
      DIR_FWD:   return CMD_FWD;
      DIR_BACK:  return CMD_BACK;
      DIR_LEFT:  return CMD_LEFT;
      DIR_RIGHT: return CMD_RIGHT;
      default:   return CMD_STOP;
    endcase
  endfunction

  // backing up never looks at a sensor
  function automatic logic path_blocked(input dir_e d, output logic [15:0] dist_cm);
    case (d)
      DIR_FWD:   dist_cm = front_cm;
      DIR_LEFT:  dist_cm = left_cm;
      DIR_RIGHT: dist_cm = right_cm;
      default: begin
        dist_cm = '0;
        return 1'b0;
      end
    endcase
    return dist_cm != set_no_echo && dist_cm <= set_block_cm;
  endfunction

  function automatic dcil_out_t make_report(input event_e ev, input logic [7:0] letter,
                                            input logic [7:0] req, input logic [15:0] dist_cm,
                                            input logic near);
    dcil_out_t r;
    r.event_res   = ev;
    r.letter      = letter;
    r.motor_dir   = motion;
    r.duty        = duty_now;
    r.req_duty    = req;
    r.distance_cm = dist_cm;
    r.near_limit  = near;
    r.last        = 1'b0;
    return r;
  endfunction

  task automatic write_setting(input logic [2:0] idx, input logic [15:0] v);
    case (idx)
      REG_DUTY_START:     set_start = v[7:0];
      REG_DUTY_MIN:       set_min = v[7:0];
      REG_DUTY_WARN:      set_warn = v[7:0];
      REG_DUTY_MAX:       set_max = v[7:0];
      REG_DUTY_STEP:      set_step = v[7:0];
      REG_BLOCK_DISTANCE: set_block_cm = v;
      REG_NO_OBJECT_CODE: set_no_echo = v;
      default: ;
    endcase
  endtask

  task automatic predict_reports(input dcil_in_t it);
    dcil_out_t   rep[2];
    int          n;
    logic [7:0]  letter;
    logic [7:0]  req;
    logic [15:0] dist_cm;
    dir_e        want_dir;
    n = 0;
    if (it.mode) begin
      front_cm = it.front_distance & DIST_MASK;
      left_cm  = it.left_distance & DIST_MASK;
      right_cm = it.right_distance & DIST_MASK;
      if (path_blocked(motion, dist_cm)) begin
        letter = motion_letter(motion);
        motion = DIR_STOP;
        rep[n[0]] = make_report(EV_OBST, letter, 8'd0, dist_cm, 1'b0);
        n = n + 1;
      end
    end else begin
      if (!it.belt_on && motion != DIR_STOP) begin
        letter = motion_letter(motion);
        motion = DIR_STOP;
        rep[n[0]] = make_report(EV_BELT, letter, 8'd0, 16'd0, 1'b0);
        n = n + 1;
      end
      case (it.cmd_byte)
        CMD_UP: begin
          req = duty_now + set_step;
          if (req > set_max) begin
            duty_now  = set_start;
            motion    = DIR_STOP;
            rep[n[0]] = make_report(EV_LIMIT, CMD_UP, req, 16'd0, 1'b0);
          end else begin
            duty_now  = req;
            rep[n[0]] = make_report(EV_ACK, CMD_UP, req, 16'd0, req >= set_warn);
          end
          n = n + 1;
        end
        CMD_DOWN: begin
          // floor test uses the wrapped sum, as the duty math does
          if (duty_now <= 8'(set_min + set_step)) duty_now = set_min;
          else duty_now = duty_now - set_step;
          rep[n[0]] = make_report(EV_ACK, CMD_DOWN, 8'd0, 16'd0, 1'b0);
          n = n + 1;
        end
        CMD_STOP: begin
          motion    = DIR_STOP;
          rep[n[0]] = make_report(EV_ACK, CMD_STOP, 8'd0, 16'd0, 1'b0);
          n = n + 1;
        end
        CMD_FWD, CMD_BACK, CMD_LEFT, CMD_RIGHT: begin
          case (it.cmd_byte)
            CMD_FWD:  want_dir = DIR_FWD;
            CMD_BACK: want_dir = DIR_BACK;
            CMD_LEFT: want_dir = DIR_LEFT;
            default:  want_dir = DIR_RIGHT;
          endcase
          if (!it.belt_on) begin
            motion    = DIR_STOP;
            rep[n[0]] = make_report(EV_BELT, it.cmd_byte, 8'd0, 16'd0, 1'b0);
          end else if (path_blocked(want_dir, dist_cm)) begin
            motion    = DIR_STOP;
            rep[n[0]] = make_report(EV_BLOCK, it.cmd_byte, 8'd0, dist_cm, 1'b0);
          end else begin
            motion    = want_dir;
            rep[n[0]] = make_report(EV_ACK, it.cmd_byte, 8'd0, 16'd0, 1'b0);
          end
          n = n + 1;
        end
        default: ;
      endcase
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) rep[i[0]].last = 1'b1;
      awaited_reports.push_back(rep[i[0]]);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_total++;
    end
  endtask

  task automatic check_report(input dcil_out_t got);
    dcil_out_t want;
    checked_total++;
    if (awaited_reports.size() == 0) begin
      $error("unexpected result: event_res %0d letter %0d motor_dir %0d", got.event_res,
             got.letter, got.motor_dir);
      fail_total++;
    end else begin
      want = awaited_reports.pop_front();
      compare_field("event_res", 16'(want.event_res), 16'(got.event_res));
      compare_field("letter", 16'(want.letter), 16'(got.letter));
      compare_field("motor_dir", 16'(want.motor_dir), 16'(got.motor_dir));
      compare_field("duty", 16'(want.duty), 16'(got.duty));
      compare_field("req_duty", 16'(want.req_duty), 16'(got.req_duty));
      compare_field("distance_cm", want.distance_cm, got.distance_cm);
      compare_field("near_limit", 16'(want.near_limit), 16'(got.near_limit));
      compare_field("last", 16'(want.last), 16'(got.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_start     = DUTY_START_RST;
      set_min       = DUTY_MIN_RST;
      set_warn      = DUTY_WARN_RST;
      set_max       = DUTY_MAX_RST;
      set_step      = DUTY_STEP_RST;
      set_block_cm  = BLOCK_DISTANCE_RST;
      set_no_echo   = NO_OBJECT_CODE_RST;
      motion        = DIR_STOP;
      duty_now      = DUTY_START_RST;
      front_cm      = NO_OBJECT_CODE_RST & DIST_MASK;
      left_cm       = NO_OBJECT_CODE_RST & DIST_MASK;
      right_cm      = NO_OBJECT_CODE_RST & DIST_MASK;
      awaited_reports.delete();
      fail_total    = 0;
      checked_total = 0;
      pending_o  <= 0;
      failures_o <= 0;
      checked_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_setting(cfg_index_i, cfg_data_i);
      // a result can't come from a transaction accepted at this same edge
      if (pop_i && !empty_i) check_report(out_item_i);
      if (push_i && !full_i) predict_reports(in_item_i);
      pending_o  <= awaited_reports.size();
      failures_o <= fail_total;
      checked_o  <= checked_total;
    end
  end

endmodule

### bench/drive_command_interlock_core_test.sv
module drive_command_interlock_core_test
  import dcil_pkg::*;
;

  localparam int DIST_BITS     = 16;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 270;
  localparam int RANDOM_PHASES = 6;

  typedef struct packed {
    logic [7:0]  start;
    logic [7:0]  floor_duty;
    logic [7:0]  warn;
    logic [7:0]  ceiling;
    logic [7:0]  duty_step;
    logic [15:0] block_cm;
    logic [15:0] no_echo;
  } drive_settings_t;

  typedef enum int {TAKE_ALL, TAKE_MOSTLY, TAKE_LONG_STALLS, TAKE_ALTERNATE} take_style_e;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;
  logic        push      = 1'b0;
  logic        full;
  dcil_in_t    in_item   = '0;
  logic        empty;
  logic        pop       = 1'b0;
  dcil_out_t   out_item;

  int pending, failures, checked;
  int cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  int settings_used = 1;
  take_style_e take_style = TAKE_ALL;
  int take_left = 0;
  int stall_left = 0;

  drive_settings_t cur = '{DUTY_START_RST, DUTY_MIN_RST, DUTY_WARN_RST, DUTY_MAX_RST,
                           DUTY_STEP_RST, BLOCK_DISTANCE_RST, NO_OBJECT_CODE_RST};

  logic [7:0] drive_letters[7] = '{CMD_UP, CMD_DOWN, CMD_STOP, CMD_FWD, CMD_BACK,
                                   CMD_LEFT, CMD_RIGHT};

  drive_command_interlock_core #(.DISTANCE_BITS(DIST_BITS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  dcil_result_checker #(.DIST_BITS(DIST_BITS)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .push_i     (push),
    .full_i     (full),
    .in_item_i  (in_item),
    .empty_i    (empty),
    .pop_i      (pop),
    .out_item_i (out_item),
    .pending_o  (pending),
    .failures_o (failures),
    .checked_o  (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: takes results in randomly picked styles, each held for a random stretch
  always @(posedge clk_i) begin
    if (take_left == 0) begin
      take_style <= take_style_e'($urandom_range(TAKE_ALL, TAKE_ALTERNATE));
      take_left  <= $urandom_range(50, 400);
    end else begin
      take_left <= take_left - 1;
    end
    if (stall_left != 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      case (take_style)
        TAKE_MOSTLY:      if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 3);
        TAKE_LONG_STALLS: if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(4, 12);
        TAKE_ALTERNATE:   if ($urandom_range(0, 1) == 0) stall_left <= 1;
        default: ;
      endcase
    end
  end

  function automatic dcil_in_t noise_item();
    dcil_in_t it;
    it.mode           = 1'($urandom_range(0, 1));
    it.cmd_byte       = 8'($urandom_range(0, 255));
    it.belt_on        = 1'($urandom_range(0, 1));
    it.front_distance = 16'($urandom_range(0, 65535));
    it.left_distance  = 16'($urandom_range(0, 65535));
    it.right_distance = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic dcil_in_t cmd_item(input logic [7:0] cmd, input logic belt);
    dcil_in_t it;
    it          = noise_item();
    it.mode     = 1'b0;
    it.cmd_byte = cmd;
    it.belt_on  = belt;
    return it;
  endfunction

  function automatic dcil_in_t dist_item(input logic [15:0] f, input logic [15:0] l,
                                         input logic [15:0] r);
    dcil_in_t it;
    it                = noise_item();
    it.mode           = 1'b1;
    it.front_distance = f;
    it.left_distance  = l;
    it.right_distance = r;
    return it;
  endfunction

  // distances cluster around the block threshold and the no-echo code
  function automatic logic [15:0] pick_distance();
    case ($urandom_range(0, 9))
      0, 1, 2: return cur.block_cm - 16'd2 + 16'($urandom_range(0, 4));
      3:       return cur.no_echo;
      4:       return 16'd0;
      5:       return 16'hFFFF;
      6, 7:    return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic dcil_in_t random_item(output logic useful);
    int pick;
    pick   = $urandom_range(0, 99);
    useful = 1'b1;
    if (pick < 20) begin
      return dist_item(pick_distance(), pick_distance(), pick_distance());
    end else if (pick < 90) begin
      return cmd_item(drive_letters[3'($urandom_range(0, 6))], $urandom_range(0, 7) != 0);
    end else begin
      useful = 1'b0;
      return cmd_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endfunction

  function automatic drive_settings_t random_settings();
    drive_settings_t s;
    s.floor_duty = 8'($urandom_range(0, 80));
    s.duty_step  = 8'($urandom_range(1, 40));
    s.warn       = 8'($urandom_range(100, 255));
    s.ceiling    = 8'($urandom_range(150, 255));
    s.start      = 8'($urandom_range(s.floor_duty, s.ceiling));
    s.block_cm   = 16'($urandom_range(0, 200));
    s.no_echo    = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(0, 300));
    return s;
  endfunction

  task automatic send_item(input dcil_in_t it);
    in_item <= it;
    push    <= 1'b1;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      push <= 1'b0;
      repeat (($urandom_range(0, 15) == 0) ? 30 : $urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // hold off until every expected result is out, then let stragglers settle
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic put_reg(input reg_e idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic apply_settings(input drive_settings_t s);
    put_reg(REG_DUTY_START, {8'd0, s.start});
    put_reg(REG_DUTY_MIN, {8'd0, s.floor_duty});
    put_reg(REG_DUTY_WARN, {8'd0, s.warn});
    put_reg(REG_DUTY_MAX, {8'd0, s.ceiling});
    put_reg(REG_DUTY_STEP, {8'd0, s.duty_step});
    put_reg(REG_BLOCK_DISTANCE, s.block_cm);
    put_reg(REG_NO_OBJECT_CODE, s.no_echo);
    cfg_valid <= 1'b0;
    cur = s;
    settings_used++;
  endtask

  initial begin
    drive_settings_t s;
    dcil_in_t        it;
    logic            useful;
    int              phase_count;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass at reset settings
    send_item(cmd_item(CMD_STOP, 1'b1));
    send_item(cmd_item(CMD_DOWN, 1'b1));
    send_item(cmd_item(CMD_FWD, 1'b1));
    send_item(dist_item(16'd10, 16'd300, 16'd300));
    send_item(dist_item(NO_OBJECT_CODE_RST, 16'd20, 16'd21));
    send_item(cmd_item(CMD_FWD, 1'b1));
    send_item(cmd_item(CMD_LEFT, 1'b1));
    send_item(cmd_item(CMD_RIGHT, 1'b1));
    send_item(cmd_item(8'h00, 1'b0));
    send_item(cmd_item(CMD_FWD, 1'b0));
    send_item(cmd_item(CMD_BACK, 1'b1));
    send_item(dist_item(16'd0, 16'd0, 16'd0));
    send_item(cmd_item(CMD_UP, 1'b0));
    // climb past the warn level into the limit reset
    repeat (7) send_item(cmd_item(CMD_UP, 1'b1));
    send_item(cmd_item(8'hFF, 1'b1));
    send_item(cmd_item(CMD_RIGHT, 1'b1));
    send_item(dist_item(16'hFFFF, 16'hFFFF, 16'hFFFF));

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: s = cur;
        1: s = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 16'hFFFF, 16'h0000};
        2: s = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 16'h0000, 16'hFFFF};
        default: s = random_settings();
      endcase
      if (phase != 0) apply_settings(s);
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        it = random_item(useful);
        send_item(it);
        if (useful) phase_count++;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("sent %0d items across %0d register settings, extremes included",
             items_sent, settings_used);
    $display("compared %0d results field by field, %0d mismatches", checked, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/dcil_pkg.sv
rtl/core/dcil_front.sv
rtl/core/dcil_queue.sv
rtl/core/dcil_back.sv
rtl/core/drive_command_interlock_core.sv
rtl/core/dcil_checker.sv
bench/dcil_result_checker.sv
bench/drive_command_interlock_core_test.sv
